### src/tss_pkg.sv
// shared types, constants and register codes for the four-row trigger step sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int MAX_ROWS       = 4;
    localparam int ROW_COUNT_DEF  = 4;
    localparam int STEP_COUNT_DEF = 16;
    localparam int COUNT_W        = 5;
    localparam int CODE_W         = 4;
    localparam int STEP_IDX_W     = 4;
    localparam int SET_W          = 2;
    localparam int ROW_PATTERN_W  = 32;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 2;
    localparam int KNOB_W         = MAX_ROWS * CODE_W;
    localparam int MUTE_W         = 2 * MAX_ROWS;
    localparam int POS_W          = MAX_ROWS * COUNT_W;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KNOB_LEN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MUTE_MASK  = 2'd3;

    localparam logic [SET_W-1:0] SET_GATE_A = 2'd2;
    localparam logic [SET_W-1:0] SET_GATE_B = 2'd0;

    localparam logic [CFG_DATA_W-1:0] PATTERN_RESET  = 64'h5555_5555_5555_5555;
    localparam logic [KNOB_W-1:0]     KNOB_RESET     = 16'hFFFF;
    localparam logic [MUTE_W-1:0]     MUTE_RESET     = 8'h00;

    typedef struct packed {
        logic run;
        logic clk;
        logic rst;
    } lvl_t;

    localparam lvl_t LVL_ROW0_DEFAULT = '{run: 1'b1, clk: 1'b0, rst: 1'b0};

    typedef struct packed {
        logic               gate_a;
        logic               gate_b;
        logic [COUNT_W-1:0] count;
    } lane_res_t;

    typedef struct packed {
        logic [MAX_ROWS-1:0] gate_upper;
        logic [MAX_ROWS-1:0] gate_lower;
        logic [POS_W-1:0]    step_positions;
    } out_item_t;

endpackage

`default_nettype wire

### src/tss_lane.sv
// one row of the sequencer: jack resolution, step counter and gate routing
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_lane #(
    parameter int STEP_COUNT = tss_pkg::STEP_COUNT_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire tss_pkg::lvl_t               lvl_above,
    input  wire logic                        run_level,
    input  wire logic                        run_patched,
    input  wire logic                        clock_level,
    input  wire logic                        clock_patched,
    input  wire logic                        reset_level,
    input  wire logic                        reset_patched,
    input  wire logic                        cv_patched,
    input  wire logic [tss_pkg::CODE_W-1:0]  cv_code,
    input  wire logic [tss_pkg::CODE_W-1:0]  knob_code,
    input  wire logic [tss_pkg::ROW_PATTERN_W-1:0] pattern,
    input  wire logic [1:0]                  mute,
    output tss_pkg::lvl_t                    lvl_out,
    output tss_pkg::lane_res_t               res
);
    import tss_pkg::*;

    localparam logic [COUNT_W-1:0] STEP_MAX = COUNT_W'(STEP_COUNT);

    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  prev_clock_reg, prev_reset_reg;
    logic [COUNT_W-1:0]    len_raw, len;
    logic [COUNT_W-1:0]    count_cleared, count_inc;
    logic [STEP_IDX_W-1:0] step_idx;
    logic [SET_W-1:0]      setting;
    logic                  active, high;

    // unpatched jacks follow the row above
    assign lvl_out.run = run_patched   ? run_level   : lvl_above.run;
    assign lvl_out.clk = clock_patched ? clock_level : lvl_above.clk;
    assign lvl_out.rst = reset_patched ? reset_level : lvl_above.rst;

    assign len_raw = {1'b0, (cv_patched ? cv_code : knob_code)} + COUNT_W'(1);
    assign len     = (len_raw > STEP_MAX) ? STEP_MAX : len_raw;

    // reset edge first, then clock edge
    assign count_cleared = (lvl_out.rst && !prev_reset_reg) ? '0 : count_reg;
    assign count_inc     = count_cleared + COUNT_W'(1);

    always_comb begin
        count_next = count_cleared;
        if (lvl_out.run && lvl_out.clk && !prev_clock_reg) begin
            count_next = (count_inc > len) ? COUNT_W'(1) : count_inc;
        end
    end

    assign step_idx = STEP_IDX_W'(count_next - COUNT_W'(1));
    assign setting  = pattern[{step_idx, 1'b0} +: SET_W];
    assign active   = (count_next != '0) && (count_next <= STEP_MAX);
    assign high     = lvl_out.run && lvl_out.clk;

    assign res.gate_a = active && (setting == SET_GATE_A) && high && !mute[0];
    assign res.gate_b = active && (setting == SET_GATE_B) && high && !mute[1];
    assign res.count  = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            prev_clock_reg <= 1'b0;
            prev_reset_reg <= 1'b0;
        end else if (accept) begin
            count_reg      <= count_next;
            prev_clock_reg <= lvl_out.clk;
            prev_reset_reg <= lvl_out.rst;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= STEP_MAX)
        else $error("step count beyond step limit");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("step count moved without an item");

    a_edge_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(prev_clock_reg) && $stable(prev_reset_reg))
        else $error("edge history moved without an item");

endmodule

`default_nettype wire

### src/tss_merge.sv
// merges lane results into one result item and holds it in a two-entry output buffer
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_merge (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire tss_pkg::lane_res_t lane_res [tss_pkg::MAX_ROWS],
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output tss_pkg::out_item_t m_item
);
    import tss_pkg::*;

    out_item_t merged;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      pop;

    always_comb begin
        merged = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            merged.gate_upper[r] = lane_res[r].gate_a;
            merged.gate_lower[r] = lane_res[r].gate_b;
            merged.step_positions[r*COUNT_W +: COUNT_W] = lane_res[r].count;
        end
    end

    assign pop = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (push) begin
            if (!out_valid_next) begin
                out_data_next  = merged;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = merged;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output stage");

    a_empty_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !out_valid_reg |=> out_valid_reg && !skid_valid_reg)
        else $error("item into empty buffer not in output stage");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved forward on take");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> out_data_reg == $past(skid_data_reg))
        else $error("skid entry lost or reordered");

endmodule

`default_nettype wire

### src/four_row_trigger_step_sequencer_core.sv
// top level of the four-row trigger step sequencer: config registers, row lanes, merge
// depends on tss_pkg, tss_lane, tss_merge
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  input    | s_valid / s_ready        | s_run_*, s_clock_*, s_reset_*, s_cv_*
//  result   | m_valid / m_ready        | m_gate_upper, m_gate_lower, m_step_positions
//  config   | cfg_wr_en                | cfg_wr_index, cfg_wr_data
//
// one item per cycle while s_ready is high; its result is on the m_ side the cycle after it is taken
// unless an earlier result still waits there
// all rows are updated in parallel lanes in the accepting cycle, jack chaining runs down the rows
// a two-entry output buffer lets one more item in while a result waits; s_ready drops when both hold
// synchronous active-low reset clears counts, edge history, buffer state; presets config registers
`timescale 1ns / 1ps
`default_nettype none

module four_row_trigger_step_sequencer_core #(
    parameter int ROW_COUNT  = tss_pkg::ROW_COUNT_DEF,
    parameter int STEP_COUNT = tss_pkg::STEP_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tss_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_run_level,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_run_patched,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_clock_level,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_clock_patched,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_reset_level,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_reset_patched,
    input  wire logic [tss_pkg::MAX_ROWS-1:0]     s_cv_patched,
    input  wire logic [tss_pkg::KNOB_W-1:0]       s_cv_length_codes,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [tss_pkg::MAX_ROWS-1:0]          m_gate_upper,
    output logic [tss_pkg::MAX_ROWS-1:0]          m_gate_lower,
    output logic [tss_pkg::POS_W-1:0]             m_step_positions
);
    import tss_pkg::*;

    logic [CFG_DATA_W-1:0] pattern_lo_reg, pattern_hi_reg;
    logic [KNOB_W-1:0]     knob_len_reg;
    logic [MUTE_W-1:0]     mute_reg;
    logic                  accept;
    lvl_t                  lvl_chain [ROW_COUNT];
    lane_res_t             lane_res  [MAX_ROWS];
    out_item_t             m_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_lo_reg <= PATTERN_RESET;
            pattern_hi_reg <= PATTERN_RESET;
            knob_len_reg   <= KNOB_RESET;
            mute_reg       <= MUTE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_PATTERN_LO: pattern_lo_reg <= cfg_wr_data;
                REG_PATTERN_HI: pattern_hi_reg <= cfg_wr_data;
                REG_KNOB_LEN:   knob_len_reg   <= cfg_wr_data[KNOB_W-1:0];
                REG_MUTE_MASK:  mute_reg       <= cfg_wr_data[MUTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
        if (r < ROW_COUNT) begin : g_lane
            localparam int HALF = r % 2;
            lvl_t                     lvl_above;
            logic [ROW_PATTERN_W-1:0] row_pattern;

            if (r == 0) begin : g_top
                assign lvl_above = LVL_ROW0_DEFAULT;
            end else begin : g_chain
                assign lvl_above = lvl_chain[r-1];
            end

            assign row_pattern = (r < 2) ? pattern_lo_reg[HALF*ROW_PATTERN_W +: ROW_PATTERN_W]
                                         : pattern_hi_reg[HALF*ROW_PATTERN_W +: ROW_PATTERN_W];

            tss_lane #(
                .STEP_COUNT(STEP_COUNT)
            ) u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .accept       (accept),
                .lvl_above    (lvl_above),
                .run_level    (s_run_level[r]),
                .run_patched  (s_run_patched[r]),
                .clock_level  (s_clock_level[r]),
                .clock_patched(s_clock_patched[r]),
                .reset_level  (s_reset_level[r]),
                .reset_patched(s_reset_patched[r]),
                .cv_patched   (s_cv_patched[r]),
                .cv_code      (s_cv_length_codes[r*CODE_W +: CODE_W]),
                .knob_code    (knob_len_reg[r*CODE_W +: CODE_W]),
                .pattern      (row_pattern),
                .mute         (mute_reg[2*r +: 2]),
                .lvl_out      (lvl_chain[r]),
                .res          (lane_res[r])
            );
        end else begin : g_off
            assign lane_res[r] = '0;
        end
    end

    tss_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .lane_res(lane_res),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_gate_upper     = m_item.gate_upper;
    assign m_gate_lower     = m_item.gate_lower;
    assign m_step_positions = m_item.step_positions;

endmodule

`default_nettype wire

### sim/tb_four_row_trigger_step_sequencer_core.sv
// self-checking testbench for four_row_trigger_step_sequencer_core: a directed table,
// then random ticks over several register settings and handshake pressure levels,
// checked against an in-bench row model; depends on tss_pkg and the core
`timescale 1ns / 1ps

module tb_four_row_trigger_step_sequencer_core;

    import tss_pkg::*;

    localparam int DIR_N           = 22;
    localparam int PHASES          = 6;
    localparam int TICKS_PER_PHASE = 105;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [3:0]  run_lvl;
        logic [3:0]  run_pat;
        logic [3:0]  clk_lvl;
        logic [3:0]  clk_pat;
        logic [3:0]  rst_lvl;
        logic [3:0]  rst_pat;
        logic [3:0]  cv_pat;
        logic [15:0] cv_codes;
    } tick_t;

    typedef struct packed {
        tick_t     tick;
        logic      typed;
        out_item_t res;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [MAX_ROWS-1:0]    s_run_level;
    logic [MAX_ROWS-1:0]    s_run_patched;
    logic [MAX_ROWS-1:0]    s_clock_level;
    logic [MAX_ROWS-1:0]    s_clock_patched;
    logic [MAX_ROWS-1:0]    s_reset_level;
    logic [MAX_ROWS-1:0]    s_reset_patched;
    logic [MAX_ROWS-1:0]    s_cv_patched;
    logic [KNOB_W-1:0]      s_cv_length_codes;
    logic                   m_valid;
    logic                   m_ready;
    logic [MAX_ROWS-1:0]    m_gate_upper;
    logic [MAX_ROWS-1:0]    m_gate_lower;
    logic [POS_W-1:0]       m_step_positions;

    // row model state and register copies
    logic [4:0]  row_count [MAX_ROWS];
    logic        last_clock [MAX_ROWS];
    logic        last_reset [MAX_ROWS];
    logic [63:0] pat_lo_copy;
    logic [63:0] pat_hi_copy;
    logic [15:0] knob_copy;
    logic [7:0]  mute_copy;

    out_item_t pending_results [$];
    dir_row_t  dir_tbl [DIR_N];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;

    // random jack state carried across ticks; patch masks and CV codes vary slowly
    logic [3:0]  clk_drive = 4'h0;
    logic [3:0]  run_pat_hold = 4'hF;
    logic [3:0]  clk_pat_hold = 4'hF;
    logic [3:0]  rst_pat_hold = 4'hF;
    logic [3:0]  cv_pat_hold = 4'h0;
    logic [15:0] cv_codes_hold = 16'h0;

    four_row_trigger_step_sequencer_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_run_level      (s_run_level),
        .s_run_patched    (s_run_patched),
        .s_clock_level    (s_clock_level),
        .s_clock_patched  (s_clock_patched),
        .s_reset_level    (s_reset_level),
        .s_reset_patched  (s_reset_patched),
        .s_cv_patched     (s_cv_patched),
        .s_cv_length_codes(s_cv_length_codes),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_gate_upper     (m_gate_upper),
        .m_gate_lower     (m_gate_lower),
        .m_step_positions (m_step_positions)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // one tick through all rows, jacks chained down from row 0
    function automatic out_item_t step_rows(input tick_t t);
        out_item_t   o;
        logic        run;
        logic        clk;
        logic        rst;
        logic [4:0]  len;
        logic [4:0]  cnt;
        logic [1:0]  setting;
        logic [63:0] word;
        int          r;
        o   = '0;
        run = 1'b1;
        clk = 1'b0;
        rst = 1'b0;
        for (r = 0; r < MAX_ROWS; r++) begin
            if (t.run_pat[r]) run = t.run_lvl[r];
            if (t.clk_pat[r]) clk = t.clk_lvl[r];
            if (t.rst_pat[r]) rst = t.rst_lvl[r];
            len = {1'b0, (t.cv_pat[r] ? t.cv_codes[4*r +: 4] : knob_copy[4*r +: 4])} + 5'd1;
            if (len > 5'd16) len = 5'd16;
            cnt = row_count[r];
            if (rst && !last_reset[r]) cnt = 5'd0;
            if (run && clk && !last_clock[r]) begin
                cnt = cnt + 5'd1;
                if (cnt > len) cnt = 5'd1;
            end
            row_count[r]  = cnt;
            last_clock[r] = clk;
            last_reset[r] = rst;
            word = (r < 2) ? pat_lo_copy : pat_hi_copy;
            if (cnt >= 5'd1 && cnt <= 5'd16) begin
                setting = word[(r % 2) * 32 + (int'(cnt) - 1) * 2 +: 2];
                o.gate_upper[r] = (setting == SET_GATE_A) && run && clk && !mute_copy[2*r];
                o.gate_lower[r] = (setting == SET_GATE_B) && run && clk && !mute_copy[2*r+1];
            end
            o.step_positions[5*r +: 5] = cnt;
        end
        return o;
    endfunction

    function automatic logic [3:0] sparse_bits(input int one_in);
        logic [3:0] v;
        int         b;
        for (b = 0; b < 4; b++) v[b] = ($urandom_range(one_in - 1) == 0);
        return v;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(9) == 0) begin
            // noise
            t = tick_t'({$urandom, $urandom});
        end else begin
            if ($urandom_range(15) == 0) begin
                run_pat_hold = ($urandom_range(2) == 0) ? 4'hF : 4'($urandom_range(15));
                clk_pat_hold = ($urandom_range(2) == 0) ? 4'hF : 4'($urandom_range(15));
                rst_pat_hold = 4'($urandom_range(15));
            end
            if ($urandom_range(39) == 0) begin
                cv_pat_hold   = 4'($urandom_range(15));
                cv_codes_hold = 16'($urandom);
            end
            clk_drive  = clk_drive ^ ~sparse_bits(4);
            t.run_lvl  = ~sparse_bits(8);
            t.run_pat  = run_pat_hold;
            t.clk_lvl  = clk_drive;
            t.clk_pat  = clk_pat_hold;
            t.rst_lvl  = sparse_bits(24);
            t.rst_pat  = rst_pat_hold;
            t.cv_pat   = cv_pat_hold;
            t.cv_codes = cv_codes_hold;
        end
        return t;
    endfunction

    function automatic dir_row_t dir_entry(input logic [3:0] rl, input logic [3:0] rp,
                                           input logic [3:0] cl, input logic [3:0] cp,
                                           input logic [3:0] tl, input logic [3:0] tp,
                                           input logic [3:0] vp, input logic [15:0] codes,
                                           input logic typed, input out_item_t res);
        dir_row_t d;
        d.tick  = '{run_lvl: rl, run_pat: rp, clk_lvl: cl, clk_pat: cp,
                    rst_lvl: tl, rst_pat: tp, cv_pat: vp, cv_codes: codes};
        d.typed = typed;
        d.res   = res;
        return d;
    endfunction

    task automatic offer_tick(input tick_t t, input logic typed, input out_item_t res);
        out_item_t pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_run_level       <= t.run_lvl;
        s_run_patched     <= t.run_pat;
        s_clock_level     <= t.clk_lvl;
        s_clock_patched   <= t.clk_pat;
        s_reset_level     <= t.rst_lvl;
        s_reset_patched   <= t.rst_pat;
        s_cv_patched      <= t.cv_pat;
        s_cv_length_codes <= t.cv_codes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = step_rows(t);
        pending_results.push_back(typed ? res : pred);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            REG_PATTERN_LO: pat_lo_copy = data;
            REG_PATTERN_HI: pat_hi_copy = data;
            REG_KNOB_LEN:   knob_copy   = data[15:0];
            REG_MUTE_MASK:  mute_copy   = data[7:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [15:0] knob, input logic [7:0] mute);
        write_reg(REG_PATTERN_LO, lo);
        write_reg(REG_PATTERN_HI, hi);
        write_reg(REG_KNOB_LEN, {48'h0, knob});
        write_reg(REG_MUTE_MASK, {56'h0, mute});
        cfg_wr_en <= 1'b0;
    endtask

    // result side
    always @(posedge aclk) begin
        out_item_t want;
        out_item_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{gate_upper: m_gate_upper, gate_lower: m_gate_lower,
                    step_positions: m_step_positions};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: expected no item, got %h %h %h",
                             $time, got.gate_upper, got.gate_lower, got.step_positions);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected %h %h %h, got %h %h %h",
                                 $time, want.gate_upper, want.gate_lower, want.step_positions,
                                 got.gate_upper, got.gate_lower, got.step_positions);
                end
            end
        end
    end

    initial begin
        int i;
        int p;
        int r;
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_index      = '0;
        cfg_wr_data       = '0;
        s_valid           = 1'b0;
        s_run_level       = '0;
        s_run_patched     = '0;
        s_clock_level     = '0;
        s_clock_patched   = '0;
        s_reset_level     = '0;
        s_reset_patched   = '0;
        s_cv_patched      = '0;
        s_cv_length_codes = '0;
        m_ready           = 1'b1;
        pat_lo_copy       = PATTERN_RESET;
        pat_hi_copy       = PATTERN_RESET;
        knob_copy         = KNOB_RESET;
        mute_copy         = MUTE_RESET;
        for (r = 0; r < MAX_ROWS; r++) begin
            row_count[r]  = 5'd0;
            last_clock[r] = 1'b0;
            last_reset[r] = 1'b0;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // mixed gate settings, short and full lengths
        program_regs(64'hD2D2_D2D2_D2D2_D2D2, 64'h0000_FFFF_AAAA_AAAA, 16'h3F10, 8'h00);

        dir_tbl[0]  = dir_entry(4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b1, '0);
        // all jacks open: row 0 defaults carry down
        dir_tbl[1]  = dir_entry(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 16'h0000, 1'b1, '0);
        dir_tbl[2]  = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[3]  = dir_entry(4'hF, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[4]  = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[5]  = dir_entry(4'hF, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        // reset and clock edges together
        dir_tbl[6]  = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[7]  = dir_entry(4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[8]  = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        // only row 0 patched, lower rows copy
        dir_tbl[9]  = dir_entry(4'hF, 4'h1, 4'h0, 4'h1, 4'h0, 4'h1, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[10] = dir_entry(4'hF, 4'h1, 4'h1, 4'h1, 4'h0, 4'h1, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[11] = dir_entry(4'h0, 4'h1, 4'h0, 4'h1, 4'h0, 4'h1, 4'h0, 16'h0000, 1'b0, '0);
        // run low holds the count
        dir_tbl[12] = dir_entry(4'h0, 4'h1, 4'h1, 4'h1, 4'h0, 4'h1, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[13] = dir_entry(4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h1, 4'hF, 16'hFFFF, 1'b0, '0);
        dir_tbl[14] = dir_entry(4'h0, 4'h0, 4'h1, 4'h1, 4'h0, 4'h1, 4'hF, 16'hFFFF, 1'b0, '0);
        dir_tbl[15] = dir_entry(4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h1, 4'hF, 16'hFFFF, 1'b0, '0);
        // length shrinks below the count, wraps to 1
        dir_tbl[16] = dir_entry(4'h0, 4'h0, 4'h1, 4'h1, 4'h0, 4'h1, 4'hF, 16'h0000, 1'b0, '0);
        dir_tbl[17] = dir_entry(4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'hF, 4'hF, 16'h0000, 1'b0, '0);
        dir_tbl[18] = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'hF, 4'hA, 16'h5A5A, 1'b0, '0);
        // clock held high, no edge
        dir_tbl[19] = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'hF, 4'h0, 16'h0000, 1'b0, '0);
        dir_tbl[20] = dir_entry(4'hF, 4'hF, 4'h0, 4'hF, 4'hF, 4'hF, 4'h0, 16'h0000, 1'b1, '0);
        dir_tbl[21] = dir_entry(4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'hF, 4'h5, 16'hF0F0, 1'b0, '0);

        for (i = 0; i < DIR_N; i++) offer_tick(dir_tbl[i].tick, dir_tbl[i].typed, dir_tbl[i].res);

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: program_regs(64'h0, 64'h0, 16'hFFFF, 8'h00);
                1: program_regs({64{1'b1}}, {64{1'b1}}, 16'h0000, 8'h55);
                2: program_regs(64'hAAAA_AAAA_AAAA_AAAA, {$urandom, $urandom},
                                16'($urandom), 8'($urandom));
                3: program_regs({$urandom, $urandom}, {$urandom, $urandom},
                                16'($urandom), 8'($urandom));
                4: program_regs({$urandom, $urandom}, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF, 8'h00);
                default: program_regs({$urandom, $urandom}, {$urandom, $urandom},
                                      16'($urandom), 8'hFF);
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            for (i = 0; i < TICKS_PER_PHASE; i++) begin
                // sender holds off until every result is back
                if (p == 2 && i == TICKS_PER_PHASE / 2) drain_results();
                offer_tick(random_tick(), 1'b0, '0);
            end
        end

        drain_results();
        rx_stall_pct = 0;
        repeat (5) @(negedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
